// ===== src/assert_macros.svh =====
// shared assertion macros for the keyboard report tracker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define HKRT_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication, disabled during reset
`define HKRT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== src/hkrt_pkg.sv =====
`timescale 1ns / 1ps

package hkrt_pkg;

    localparam int KEY_SLOTS_DEF = 6;
    localparam int OUT_SLOTS     = 6;

    localparam logic [7:0] MOD_FIRST = 8'hE0;
    localparam logic [7:0] MOD_LAST  = 8'hE7;

    typedef logic [1:0] kind_t;

    localparam kind_t KIND_PRESS   = 2'd0;
    localparam kind_t KIND_RELEASE = 2'd1;
    localparam kind_t KIND_CLEAR   = 2'd2;
    localparam kind_t KIND_NONE    = 2'd3;

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_SCAN  = 4'b0010,
        ST_SHIFT = 4'b0100,
        ST_EMIT  = 4'b1000
    } state_t;

endpackage

// ===== src/hid_keyboard_report_tracker.sv =====
`timescale 1ns / 1ps

// Boot keyboard report tracker: keeps a modifier bitmap and KEY_SLOTS packed key slots and
// sends a full report (modifiers plus the first six slots) on every change the host should
// see. Modifier events and clears are resolved in the accept cycle; an accepted event that
// sends a report then loads the report register from ST_EMIT. Key presses and releases
// walk the slots with one shared compare unit, one slot per cycle: a press scans from
// slot 0 to the first empty or matching slot and writes the key into an empty one, a
// release scans for the key and then shifts the later keys down, clearing the last slot.
// Events that send nothing free the input after the last slot looked at. A finished report
// waits in the output register while the next event is taken; the block stalls in its
// report cycle only while an earlier report is still stalled.
module hid_keyboard_report_tracker #(
    parameter int KEY_SLOTS = hkrt_pkg::KEY_SLOTS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              event_valid,
    output logic              event_stall,
    input  hkrt_pkg::kind_t   kind,
    input  logic [7:0]        key_code,
    input  logic              link_ready,
    output logic              report_valid,
    input  logic              report_stall,
    output logic [7:0]        modifier_bits,
    output logic [7:0]        slot_0,
    output logic [7:0]        slot_1,
    output logic [7:0]        slot_2,
    output logic [7:0]        slot_3,
    output logic [7:0]        slot_4,
    output logic [7:0]        slot_5
);
    import hkrt_pkg::*;

    localparam int IDX_W = (KEY_SLOTS > 1) ? $clog2(KEY_SLOTS) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(KEY_SLOTS - 1);

    state_t            state_reg, state_next;
    logic [IDX_W-1:0]  idx_reg, idx_next;
    kind_t             kind_reg, kind_next;
    logic [7:0]        code_reg, code_next;
    logic [7:0]        mods_reg, mods_next;
    logic [7:0]        slots_reg [KEY_SLOTS];
    logic [7:0]        slots_next [KEY_SLOTS];
    logic              rep_valid_reg, rep_valid_next;
    logic [7:0]        rep_mods_reg;
    logic [7:0]        rep_slots_reg [OUT_SLOTS];

    logic              ev_acc;
    logic              load_rep;
    logic              is_last;
    logic [IDX_W-1:0]  rd_addr;
    logic [7:0]        cur;
    logic              hit;
    logic              empty;
    logic              is_mod;
    logic [7:0]        mod_mask;
    logic [7:0]        mod_new;

    assign event_stall = (state_reg != ST_IDLE);
    assign ev_acc      = event_valid && !event_stall;

    // shared compare unit: one slot per cycle, the next slot while shifting
    assign is_last = (idx_reg == LAST_IDX);
    assign rd_addr = (state_reg == ST_SHIFT && !is_last) ? idx_reg + 1'b1 : idx_reg;
    assign cur     = slots_reg[rd_addr];
    assign hit     = (cur == code_reg);
    assign empty   = (cur == 8'd0);

    assign is_mod   = (key_code >= MOD_FIRST) && (key_code <= MOD_LAST);
    assign mod_mask = 8'd1 << key_code[2:0];
    assign mod_new  = (kind == KIND_PRESS) ? (mods_reg | mod_mask) : (mods_reg & ~mod_mask);

    always_comb
    begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        kind_next      = kind_reg;
        code_next      = code_reg;
        mods_next      = mods_reg;
        slots_next     = slots_reg;
        rep_valid_next = rep_valid_reg;
        load_rep       = 1'b0;

        if (rep_valid_reg && !report_stall)
        begin
            rep_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (ev_acc)
                begin
                    kind_next = kind;
                    code_next = key_code;
                    idx_next  = '0;
                    if (kind == KIND_CLEAR)
                    begin
                        for (int i = 0; i < KEY_SLOTS; i++)
                        begin
                            slots_next[i] = 8'd0;
                        end
                        if (link_ready)
                        begin
                            state_next = ST_EMIT;
                        end
                    end
                    else if (kind inside {KIND_PRESS, KIND_RELEASE} && link_ready)
                    begin
                        if (is_mod)
                        begin
                            mods_next = mod_new;
                            if (mod_new != mods_reg)
                            begin
                                state_next = ST_EMIT;
                            end
                        end
                        else
                        begin
                            state_next = ST_SCAN;
                        end
                    end
                end
            end

            ST_SCAN:
            begin
                if (kind_reg == KIND_PRESS)
                begin
                    if (empty)
                    begin
                        slots_next[idx_reg] = code_reg;
                        state_next          = ST_EMIT;
                    end
                    else if (hit || is_last)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        idx_next = idx_reg + 1'b1;
                    end
                end
                else
                begin
                    // a match is checked before an empty slot, so usage zero finds a hole
                    if (hit)
                    begin
                        state_next = ST_SHIFT;
                    end
                    else if (empty || is_last)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        idx_next = idx_reg + 1'b1;
                    end
                end
            end

            ST_SHIFT:
            begin
                if (is_last)
                begin
                    slots_next[idx_reg] = 8'd0;
                    state_next          = ST_EMIT;
                end
                else
                begin
                    slots_next[idx_reg] = cur;
                    idx_next            = idx_reg + 1'b1;
                end
            end

            ST_EMIT:
            begin
                if (!rep_valid_reg || !report_stall)
                begin
                    load_rep       = 1'b1;
                    rep_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            idx_reg       <= '0;
            kind_reg      <= KIND_NONE;
            mods_reg      <= 8'd0;
            rep_valid_reg <= 1'b0;
            for (int i = 0; i < KEY_SLOTS; i++)
            begin
                slots_reg[i] <= 8'd0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            kind_reg      <= kind_next;
            mods_reg      <= mods_next;
            rep_valid_reg <= rep_valid_next;
            slots_reg     <= slots_next;
        end
    end

    always_ff @(posedge clk)
    begin
        code_reg <= code_next;
        if (load_rep)
        begin
            rep_mods_reg <= mods_reg;
        end
    end

    // slots past KEY_SLOTS read as empty in the report
    for (genvar j = 0; j < OUT_SLOTS; j++)
    begin : g_rep
        if (j < KEY_SLOTS)
        begin : g_held
            always_ff @(posedge clk)
            begin
                if (load_rep)
                begin
                    rep_slots_reg[j] <= slots_reg[j];
                end
            end
        end
        else
        begin : g_unused
            always_ff @(posedge clk)
            begin
                if (load_rep)
                begin
                    rep_slots_reg[j] <= 8'd0;
                end
            end
        end
    end

    assign report_valid  = rep_valid_reg;
    assign modifier_bits = rep_mods_reg;
    assign slot_0        = rep_slots_reg[0];
    assign slot_1        = rep_slots_reg[1];
    assign slot_2        = rep_slots_reg[2];
    assign slot_3        = rep_slots_reg[3];
    assign slot_4        = rep_slots_reg[4];
    assign slot_5        = rep_slots_reg[5];

endmodule

// ===== src/hkrt_checker.sv =====
`timescale 1ns / 1ps

`include "assert_macros.svh"

module hkrt_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              event_valid,
    input logic              event_stall,
    input hkrt_pkg::kind_t   kind,
    input logic              link_ready,
    input logic              report_valid,
    input logic              report_stall,
    input logic [7:0]        modifier_bits,
    input logic [7:0]        slot_0,
    input logic [7:0]        slot_1,
    input logic [7:0]        slot_2,
    input logic [7:0]        slot_3,
    input logic [7:0]        slot_4,
    input logic [7:0]        slot_5
);
    import hkrt_pkg::*;

    logic        ev_acc;
    logic        rep_wait;
    logic [55:0] rep_bus;

    assign ev_acc   = event_valid && !event_stall;
    assign rep_wait = report_valid && report_stall;
    assign rep_bus  = {modifier_bits, slot_0, slot_1, slot_2, slot_3, slot_4, slot_5};

    // a stalled report keeps its contents
    `HKRT_ASSERT_NEXT(a_report_hold, clk, rst_n, rep_wait, report_valid && $stable(rep_bus))

    // the unused event code frees the input right away
    `HKRT_ASSERT_NEXT(a_none_quick, clk, rst_n, ev_acc && kind == KIND_NONE, !event_stall)

    // with the link down only a clear touches state, and nothing waits to be sent
    `HKRT_ASSERT_NEXT(a_link_down_quick, clk, rst_n, ev_acc && !link_ready, !event_stall)

    // a fresh report only appears out of the report cycle of an event
    `HKRT_ASSERT_SAME(a_report_source, clk, rst_n, $rose(report_valid), $past(event_stall))

endmodule

bind hid_keyboard_report_tracker hkrt_checker u_hkrt_checker (.*);
